>>> rtl/joystick_to_gimbal_position_macros.svh
// ---------------------------------------------------------------------------
// joystick_to_gimbal_position assertion macros
// Shorthand for the concurrent checks used in the checker.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_TO_GIMBAL_POSITION_MACROS_SVH
`define JOYSTICK_TO_GIMBAL_POSITION_MACROS_SVH

// Check that is switched off while reset is high
`define JTGP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset
`define JTGP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/jtgp_pkg.sv
// ---------------------------------------------------------------------------
// jtgp_pkg
// Shared types, register map and helpers for the joystick to gimbal block.
// ---------------------------------------------------------------------------
package jtgp_pkg;

   localparam int HISTORY_DEPTH = 4;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   // Register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_BAND_LOW  = 3'd0;
   localparam logic [2:0] REG_BAND_HIGH = 3'd1;
   localparam logic [2:0] REG_PAN_MIN   = 3'd2;
   localparam logic [2:0] REG_PAN_MAX   = 3'd3;
   localparam logic [2:0] REG_TILT_MIN  = 3'd4;
   localparam logic [2:0] REG_TILT_MAX  = 3'd5;

   localparam logic [11:0] BAND_LOW_RST  = 12'd1400;
   localparam logic [11:0] BAND_HIGH_RST = 12'd1600;
   localparam logic signed [9:0] POS_MIN_RST = -10'sd90;
   localparam logic signed [9:0] POS_MAX_RST = 10'sd90;

   typedef enum logic [2:0] {
      SYM_HOME,
      SYM_L,
      SYM_R,
      SYM_U,
      SYM_D
   } jtgp_sym_type;

   // Entry 0 is the oldest move
   typedef jtgp_sym_type [HISTORY_DEPTH-1:0] jtgp_hist_type;

   typedef struct packed {
      logic [11:0]        band_low;
      logic [11:0]        band_high;
      logic signed [9:0]  pan_min;
      logic signed [9:0]  pan_max;
      logic signed [9:0]  tilt_min;
      logic signed [9:0]  tilt_max;
   } jtgp_cfg_type;

   typedef struct packed {
      logic signed [9:0]  pan;
      logic signed [9:0]  tilt;
      jtgp_hist_type      hist;
   } jtgp_state_type;

   function automatic jtgp_hist_type hist_push(jtgp_hist_type h, jtgp_sym_type s);
      jtgp_hist_type r;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         r[i] = h[i+1];
      end
      r[HISTORY_DEPTH-1] = s;
      return r;
   endfunction

endpackage

>>> rtl/jtgp_csr.sv
// ---------------------------------------------------------------------------
// jtgp_csr
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module jtgp_csr
   import jtgp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready,
   output jtgp_cfg_type           cfg
);

   jtgp_cfg_type cfg_ff;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_low  <= BAND_LOW_RST;
         cfg_ff.band_high <= BAND_HIGH_RST;
         cfg_ff.pan_min   <= POS_MIN_RST;
         cfg_ff.pan_max   <= POS_MAX_RST;
         cfg_ff.tilt_min  <= POS_MIN_RST;
         cfg_ff.tilt_max  <= POS_MAX_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BAND_LOW:  cfg_ff.band_low  <= csr_pwdata[11:0];
            REG_BAND_HIGH: cfg_ff.band_high <= csr_pwdata[11:0];
            REG_PAN_MIN:   cfg_ff.pan_min   <= csr_pwdata[9:0];
            REG_PAN_MAX:   cfg_ff.pan_max   <= csr_pwdata[9:0];
            REG_TILT_MIN:  cfg_ff.tilt_min  <= csr_pwdata[9:0];
            REG_TILT_MAX:  cfg_ff.tilt_max  <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BAND_LOW:  csr_prdata = {20'd0, cfg_ff.band_low};
         REG_BAND_HIGH: csr_prdata = {20'd0, cfg_ff.band_high};
         REG_PAN_MIN:   csr_prdata = {{22{cfg_ff.pan_min[9]}}, cfg_ff.pan_min};
         REG_PAN_MAX:   csr_prdata = {{22{cfg_ff.pan_max[9]}}, cfg_ff.pan_max};
         REG_TILT_MIN:  csr_prdata = {{22{cfg_ff.tilt_min[9]}}, cfg_ff.tilt_min};
         REG_TILT_MAX:  csr_prdata = {{22{cfg_ff.tilt_max[9]}}, cfg_ff.tilt_max};
         default:       csr_prdata = '0;
      endcase
   end

endmodule

>>> rtl/jtgp_step.sv
// ---------------------------------------------------------------------------
// jtgp_step
// Next-state logic for one pulse pair: dead band, saturating steps, homing.
// ---------------------------------------------------------------------------
module jtgp_step
   import jtgp_pkg::*;
(
   input  jtgp_cfg_type    cfg,
   input  jtgp_state_type  cur,
   input  logic [11:0]     pulse_h,
   input  logic [11:0]     pulse_v,
   output jtgp_state_type  nxt,
   output logic            homed
);

   logic signed [10:0] pan_up, pan_dn, tilt_up, tilt_dn;
   logic signed [9:0]  pan_up_sat, pan_dn_sat, tilt_up_sat, tilt_dn_sat;
   logic               h_lo, h_hi, v_lo, v_hi;
   jtgp_hist_type      hist_h, hist_v;

   assign h_lo = pulse_h < cfg.band_low;
   assign h_hi = !h_lo && (pulse_h > cfg.band_high);
   assign v_lo = pulse_v < cfg.band_low;
   assign v_hi = !v_lo && (pulse_v > cfg.band_high);

   // 11-bit sums so the step cannot wrap before the clamp
   assign pan_up  = {cur.pan[9], cur.pan} + 11'sd1;
   assign pan_dn  = {cur.pan[9], cur.pan} - 11'sd1;
   assign tilt_up = {cur.tilt[9], cur.tilt} + 11'sd1;
   assign tilt_dn = {cur.tilt[9], cur.tilt} - 11'sd1;

   assign pan_up_sat  = (pan_up > $signed({cfg.pan_max[9], cfg.pan_max})) ?
                        cfg.pan_max : pan_up[9:0];
   assign pan_dn_sat  = (pan_dn < $signed({cfg.pan_min[9], cfg.pan_min})) ?
                        cfg.pan_min : pan_dn[9:0];
   assign tilt_up_sat = (tilt_up > $signed({cfg.tilt_max[9], cfg.tilt_max})) ?
                        cfg.tilt_max : tilt_up[9:0];
   assign tilt_dn_sat = (tilt_dn < $signed({cfg.tilt_min[9], cfg.tilt_min})) ?
                        cfg.tilt_min : tilt_dn[9:0];

   always_comb begin
      hist_h = cur.hist;
      if (h_lo) begin
         hist_h = hist_push(cur.hist, SYM_L);
      end else if (h_hi) begin
         hist_h = hist_push(cur.hist, SYM_R);
      end

      hist_v = hist_h;
      if (v_lo) begin
         hist_v = hist_push(hist_h, SYM_U);
      end else if (v_hi) begin
         hist_v = hist_push(hist_h, SYM_D);
      end

      homed = (hist_v[0] == SYM_L) && (hist_v[1] == SYM_R) &&
              (hist_v[2] == SYM_L) && (hist_v[3] == SYM_R);

      if (homed) begin
         nxt.pan  = '0;
         nxt.tilt = '0;
         nxt.hist = hist_push(hist_v, SYM_HOME);
      end else begin
         nxt.pan  = h_lo ? pan_dn_sat : (h_hi ? pan_up_sat : cur.pan);
         nxt.tilt = v_lo ? tilt_up_sat : (v_hi ? tilt_dn_sat : cur.tilt);
         nxt.hist = hist_v;
      end
   end

endmodule

>>> rtl/joystick_to_gimbal_position.sv
// ---------------------------------------------------------------------------
// joystick_to_gimbal_position
// Steps pan and tilt positions from stick pulse widths, with l,r,l,r homing.
// ---------------------------------------------------------------------------
// Channel   | Direction | Contents
// req_      | in        | pulse_h, pulse_v
// rsp_      | out       | pan_pos, tilt_pos, homed (tuser)
// csr_      | in        | six config registers at 4*index
//
// One request per cycle while the result is not stalled; the input register loads
// at the accepting edge, the result register once it is free or being drained.
// Position and history update combinationally between the two registers.
// A stalled result holds the result register; the input register still takes
// one more request behind it.
// Reset clears positions to 0, history to home and restores default limits.
// ---------------------------------------------------------------------------
module joystick_to_gimbal_position
   import jtgp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // [11:0] pulse_h, [23:12] pulse_v
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // [9:0] pan_pos, [19:10] tilt_pos, pad
   output logic                   rsp_tuser,   // [0] homed
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   jtgp_cfg_type    cfg;
   jtgp_state_type  state_ff, state_in;
   logic            in_vld_ff;
   logic [11:0]     pulse_h_ff, pulse_v_ff;
   logic            out_vld_ff;
   logic [9:0]      pan_out_ff, tilt_out_ff;
   logic            homed_ff, homed_in;
   logic            advance, fire;

   jtgp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jtgp_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .pulse_h (pulse_h_ff),
      .pulse_v (pulse_v_ff),
      .nxt     (state_in),
      .homed   (homed_in)
   );

   // result register free or being drained this cycle
   assign advance    = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pulse_h_ff <= req_tdata[11:0];
         pulse_v_ff <= req_tdata[23:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pan  <= '0;
         state_ff.tilt <= '0;
         state_ff.hist <= {HISTORY_DEPTH{SYM_HOME}};
         out_vld_ff    <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pan_out_ff  <= state_in.pan;
         tilt_out_ff <= state_in.tilt;
         homed_ff    <= homed_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, tilt_out_ff, pan_out_ff};
   assign rsp_tuser  = homed_ff;

endmodule

>>> rtl/jtgp_checker.sv
// ---------------------------------------------------------------------------
// jtgp_checker
// Port-level checks on the joystick to gimbal block, bound to the top level.
// ---------------------------------------------------------------------------
`include "joystick_to_gimbal_position_macros.svh"

module jtgp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser
);

   // nothing in flight straight after reset
   `JTGP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_tvalid && req_tready), "not empty after reset")

   // a homing result carries both positions at zero
   `JTGP_ASSERT(a_homed_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[19:0] == 20'd0), "homed with non-zero position")

   // stalled result holds
   `JTGP_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result changed")

   // a request taken behind a stalled result fills the pipe: ready then follows the sink
   `JTGP_ASSERT(a_full_backpressure, clock, reset, (rsp_tvalid && !rsp_tready && req_tvalid && req_tready) |=> (req_tready == rsp_tready), "request ready not tied to sink when full")

endmodule

bind joystick_to_gimbal_position jtgp_checker u_jtgp_checker (.*);

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// joystick_to_gimbal_position testbench
// Drives pulse-width requests over the req_ stream, rewrites the band and
// limit registers over the csr_ port between phases and predicts each pan,
// tilt and homed result. Results are checked in order as they leave rsp_.
// ---------------------------------------------------------------------------
module testbench;
   import jtgp_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int SWEEP_ITEMS = 108;
   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;

   typedef struct packed {
      logic signed [9:0] pan;
      logic signed [9:0] tilt;
      logic              homed;
   } gimbal_pos_type;

   typedef enum int {PULSE_BELOW, PULSE_INSIDE, PULSE_ABOVE, PULSE_ANY} pulse_class_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;    // [11:0] pulse_h, [23:12] pulse_v
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;         // [9:0] pan_pos, [19:10] tilt_pos, pad
   logic                  rsp_tuser;         // [0] homed
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor copy of configuration and state
   logic [11:0]       cfg_band_low = BAND_LOW_RST;
   logic [11:0]       cfg_band_high = BAND_HIGH_RST;
   logic signed [9:0] cfg_pan_min = POS_MIN_RST;
   logic signed [9:0] cfg_pan_max = POS_MAX_RST;
   logic signed [9:0] cfg_tilt_min = POS_MIN_RST;
   logic signed [9:0] cfg_tilt_max = POS_MAX_RST;
   logic signed [9:0] pan_now = '0;
   logic signed [9:0] tilt_now = '0;
   jtgp_hist_type     moves = {HISTORY_DEPTH{SYM_HOME}};

   gimbal_pos_type expected_positions[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          rsp_hold_request = 0;
   int          rsp_hold_left = 0;
   int          idle_cycles = 0;

   joystick_to_gimbal_position dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [9:0] step_up(logic signed [9:0] pos,
                                                 logic signed [9:0] hi);
      int n;
      n = int'(pos) + 1;
      return (n > int'(hi)) ? hi : 10'(n);
   endfunction

   function automatic logic signed [9:0] step_down(logic signed [9:0] pos,
                                                   logic signed [9:0] lo);
      int n;
      n = int'(pos) - 1;
      return (n < int'(lo)) ? lo : 10'(n);
   endfunction

   function automatic void record_move(jtgp_sym_type sym);
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         moves[i] = moves[i+1];
      end
      moves[HISTORY_DEPTH-1] = sym;
   endfunction

   function automatic gimbal_pos_type predict_gimbal_step(logic [11:0] ph, logic [11:0] pv);
      gimbal_pos_type r;
      r.homed = 1'b0;
      if (ph < cfg_band_low) begin
         record_move(SYM_L);
         pan_now = step_down(pan_now, cfg_pan_min);
      end else if (ph > cfg_band_high) begin
         record_move(SYM_R);
         pan_now = step_up(pan_now, cfg_pan_max);
      end
      // vertical axis is inverted: a short pulse tilts up
      if (pv < cfg_band_low) begin
         record_move(SYM_U);
         tilt_now = step_up(tilt_now, cfg_tilt_max);
      end else if (pv > cfg_band_high) begin
         record_move(SYM_D);
         tilt_now = step_down(tilt_now, cfg_tilt_min);
      end
      if (moves[0] == SYM_L && moves[1] == SYM_R && moves[2] == SYM_L && moves[3] == SYM_R) begin
         record_move(SYM_HOME);
         pan_now = '0;
         tilt_now = '0;
         r.homed = 1'b1;
      end
      r.pan = pan_now;
      r.tilt = tilt_now;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [11:0] pulse_in_class(pulse_class_type cls);
      int lo;
      int hi;
      lo = cfg_band_low;
      hi = cfg_band_high;
      case (cls)
         PULSE_BELOW: begin
            if (lo > 0)
               return ($urandom_range(0, 3) == 0) ? 12'(lo - 1) : 12'($urandom_range(0, lo - 1));
         end
         PULSE_INSIDE: begin
            if (lo <= hi) begin
               case ($urandom_range(0, 9))
                  0: return 12'(lo);
                  1: return 12'(hi);
                  default: return 12'($urandom_range(lo, hi));
               endcase
            end
         end
         PULSE_ABOVE: begin
            if (hi < 4095)
               return ($urandom_range(0, 3) == 0) ? 12'(hi + 1) : 12'($urandom_range(hi + 1, 4095));
         end
         default: ;
      endcase
      return 12'($urandom_range(0, 4095));
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken
   task automatic send_pulse(logic [11:0] ph, logic [11:0] pv);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pv, ph};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_positions.push_back(predict_gimbal_step(ph, pv));
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BAND_LOW:  cfg_band_low = value[11:0];
         REG_BAND_HIGH: cfg_band_high = value[11:0];
         REG_PAN_MIN:   cfg_pan_min = value[9:0];
         REG_PAN_MAX:   cfg_pan_max = value[9:0];
         REG_TILT_MIN:  cfg_tilt_min = value[9:0];
         REG_TILT_MAX:  cfg_tilt_max = value[9:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // random junk above the field, which the block should drop
   function automatic logic [31:0] with_noise(int field, int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 32'd1;
      return ($urandom() & ~mask) | (32'(field) & mask);
   endfunction

   task automatic write_setting(int bl, int bh, int pmin, int pmax, int tmin, int tmax);
      csr_write(REG_BAND_LOW, with_noise(bl, 12));
      csr_write(REG_BAND_HIGH, with_noise(bh, 12));
      csr_write(REG_PAN_MIN, with_noise(pmin, 10));
      csr_write(REG_PAN_MAX, with_noise(pmax, 10));
      csr_write(REG_TILT_MIN, with_noise(tmin, 10));
      csr_write(REG_TILT_MAX, with_noise(tmax, 10));
   endtask

   // l,r,l,r on the stick with the vertical centred, sometimes spoilt
   task automatic send_homing_run(output int sent);
      int spoil;
      spoil = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
      for (int k = 0; k < 4; k++) begin
         if (k == spoil)
            send_pulse(pulse_in_class(PULSE_ANY),
                       pulse_in_class(pulse_class_type'($urandom_range(0, 3))));
         else
            send_pulse(pulse_in_class((k % 2 == 0) ? PULSE_BELOW : PULSE_ABOVE),
                       pulse_in_class(PULSE_INSIDE));
      end
      sent = 4;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_moves();
      send_idle_pct = 13;
      recv_idle_pct = 81;
      send_pulse(12'd1500, 12'd1500);
      send_pulse(12'd0, 12'd4095);
      send_pulse(12'd4095, 12'd0);
      send_pulse(12'd1399, 12'd1601);
      send_pulse(12'd1400, 12'd1600);
      send_pulse(12'd1601, 12'd1399);
      // homing pattern
      send_pulse(12'd1000, 12'd1500);
      send_pulse(12'd2000, 12'd1500);
      send_pulse(12'd1000, 12'd1500);
      send_pulse(12'd2000, 12'd1500);
      // vertical move in the middle breaks the pattern
      send_pulse(12'd1000, 12'd1500);
      send_pulse(12'd2000, 12'd1000);
      wait_for_idle();
   endtask

   task automatic test_limit_cases();
      // positions start outside the new limits
      write_setting(1400, 1600, 40, 90, -90, -40);
      send_pulse(12'd4095, 12'd1500);
      send_pulse(12'd0, 12'd1500);
      send_pulse(12'd1500, 12'd0);
      send_pulse(12'd1500, 12'd4095);
      wait_for_idle();
      // minimum above maximum
      write_setting(1400, 1600, 20, -20, 15, -15);
      send_pulse(12'd4095, 12'd0);
      send_pulse(12'd0, 12'd4095);
      wait_for_idle();
      // writes past the last register must change nothing
      csr_write(REG_SPARE_6, $urandom());
      csr_write(REG_SPARE_7, $urandom());
      send_pulse(12'd0, 12'd0);
      wait_for_idle();
      // inverted band: nothing is centred
      write_setting(3000, 1000, -90, 90, -90, 90);
      send_pulse(12'd2000, 12'd2000);
      send_pulse(12'd3000, 12'd3000);
      send_pulse(12'd999, 12'd3001);
      wait_for_idle();
   endtask

   task automatic apply_sweep_setting(int kind);
      int a;
      int b;
      int pmin;
      int tmin;
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
      pmin = int'($urandom_range(0, 60)) - 40;
      tmin = int'($urandom_range(0, 60)) - 20;
      case (kind)
         0: write_setting(1400, 1600, -90, 90, -90, 90);
         1: write_setting(0, 2048, -512, 511, -512, 511);
         2: write_setting(4095, 0, -3, 2, -1, 4);
         3: write_setting((a < b) ? a : b, (a < b) ? b : a, 5, -5, 20, -20);
         4: write_setting((a < b || $urandom_range(0, 4) == 0) ? a : b, (a < b) ? b : a,
                          pmin, pmin + int'($urandom_range(0, 50)) - 5,
                          tmin, tmin + int'($urandom_range(0, 50)) - 5);
         default: write_setting(2048, 4095, -512, -512, 511, 511);
      endcase
   endtask

   task automatic test_random_sweep();
      int sent;
      int run;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 13; recv_idle_pct = 81; end
            1: begin send_idle_pct = 81; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int kind = 0; kind < 6; kind++) begin
            apply_sweep_setting(kind);
            sent = 0;
            while (sent < SWEEP_ITEMS) begin
               if ($urandom_range(0, 99) < 35) begin
                  send_homing_run(run);
                  sent += run;
               end else begin
                  send_pulse(pulse_in_class(pulse_class_type'($urandom_range(0, 3))),
                             pulse_in_class(pulse_class_type'($urandom_range(0, 3))));
                  sent++;
               end
            end
            wait_for_idle();
         end
      end
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_sweep_setting(0);
      rsp_hold_request = 300;
      for (int i = 0; i < 40; i++) begin
         send_pulse(pulse_in_class(pulse_class_type'($urandom_range(0, 3))),
                    pulse_in_class(pulse_class_type'($urandom_range(0, 3))));
      end
      wait_for_idle();
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_result
      gimbal_pos_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_positions.size() == 0) begin
            report_mismatch($sformatf("result with no request pending, tdata %h", rsp_tdata));
         end else begin
            want = expected_positions.pop_front();
            if (rsp_tdata[9:0] !== want.pan)
               report_mismatch($sformatf("pan_pos got %0d expected %0d",
                                         $signed(rsp_tdata[9:0]), want.pan));
            if (rsp_tdata[19:10] !== want.tilt)
               report_mismatch($sformatf("tilt_pos got %0d expected %0d",
                                         $signed(rsp_tdata[19:10]), want.tilt));
            if (rsp_tuser !== want.homed)
               report_mismatch($sformatf("homed got %b expected %b", rsp_tuser, want.homed));
            if (rsp_tdata[23:20] !== 4'd0)
               report_mismatch($sformatf("tdata padding got %h", rsp_tdata[23:20]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
         $display("testbench failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_moves();
      test_limit_cases();
      test_random_sweep();
      test_output_stall();
      repeat (8) @(posedge clock);
      if (expected_positions.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_positions.size()));
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
